// ===== sv/tls_pkg.sv =====
`timescale 1ns / 1ps

package tls_pkg;

    localparam int FRAME_BITS = 16;
    localparam int TOTAL_BITS = 16;
    localparam int CMP_BITS   = (FRAME_BITS > TOTAL_BITS) ? FRAME_BITS : TOTAL_BITS;
    localparam int CFG_IDX_BITS = 3;
    localparam int WALK_STEPS = 5;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_BEGIN = 2'd1,
        CMD_ABORT = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        MOVE_NONE = 2'd0,
        MOVE_ABS  = 2'd1,
        MOVE_REL  = 2'd2
    } t_move;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_START_POS    = 3'd0,
        REG_STEPS        = 3'd1,
        REG_TRIGGER_MS   = 3'd2,
        REG_SHUTTER_MS   = 3'd3,
        REG_INTERVAL_MS  = 3'd4,
        REG_TOTAL_FRAMES = 3'd5
    } t_reg;

    typedef enum logic [5:0] {
        PH_IDLE     = 6'b000001,
        PH_POSITION = 6'b000010,
        PH_TRIGGER  = 6'b000100,
        PH_EXPOSE   = 6'b001000,
        PH_SHUTTLE  = 6'b010000,
        PH_WAIT     = 6'b100000
    } t_phase;

    localparam logic [2:0] CODE_IDLE     = 3'd0;
    localparam logic [2:0] CODE_POSITION = 3'd1;
    localparam logic [2:0] CODE_TRIGGER  = 3'd2;
    localparam logic [2:0] CODE_EXPOSE   = 3'd3;
    localparam logic [2:0] CODE_SHUTTLE  = 3'd4;
    localparam logic [2:0] CODE_WAIT     = 3'd5;

    typedef struct packed {
        logic signed [31:0]    start_position;
        logic signed [31:0]    steps_per_frame;
        logic [31:0]           trigger_ms;
        logic [31:0]           shutter_ms;
        logic [31:0]           interval_ms;
        logic [TOTAL_BITS-1:0] total_frames;
    } t_cfg;

    typedef struct packed {
        t_phase                phase;
        logic [31:0]           frame_start;
        logic [FRAME_BITS-1:0] count;
        logic                  shutter;
    } t_state;

    typedef struct packed {
        logic [2:0]            phase;
        logic                  shutter_line;
        t_move                 move_kind;
        logic signed [31:0]    move_amount;
        logic [TOTAL_BITS-1:0] frames_done;
        logic                  finished;
    } t_result;

    function automatic logic [2:0] phase_code(input t_phase ph);
        logic [2:0] code;
        case (ph)
            PH_IDLE:     code = CODE_IDLE;
            PH_POSITION: code = CODE_POSITION;
            PH_TRIGGER:  code = CODE_TRIGGER;
            PH_EXPOSE:   code = CODE_EXPOSE;
            PH_SHUTTLE:  code = CODE_SHUTTLE;
            PH_WAIT:     code = CODE_WAIT;
            default:     code = CODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

// ===== sv/tls_if.sv =====
`timescale 1ns / 1ps

interface tls_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [31:0] now_ms;
    logic        stepper_busy;

    modport source (output valid, cmd, now_ms, stepper_busy, input ready);
    modport sink (input valid, cmd, now_ms, stepper_busy, output ready);
endinterface

interface tls_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         phase;
    logic               shutter_line;
    logic [1:0]         move_kind;
    logic signed [31:0] move_amount;
    logic [15:0]        frames_done;
    logic               finished;

    modport source (output valid, phase, shutter_line, move_kind, move_amount,
                    frames_done, finished, input ready);
    modport sink (input valid, phase, shutter_line, move_kind, move_amount,
                  frames_done, finished, output ready);
endinterface

interface tls_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/tls_cfg_regs.sv =====
`timescale 1ns / 1ps

module tls_cfg_regs
    import tls_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    tls_cfg_if.sink    i_cfg,
    output t_cfg       o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            case (t_reg'(i_cfg.index))
                REG_START_POS:    n_cfg.start_position = i_cfg.data;
                REG_STEPS:        n_cfg.steps_per_frame = i_cfg.data;
                REG_TRIGGER_MS:   n_cfg.trigger_ms = i_cfg.data;
                REG_SHUTTER_MS:   n_cfg.shutter_ms = i_cfg.data;
                REG_INTERVAL_MS:  n_cfg.interval_ms = i_cfg.data;
                REG_TOTAL_FRAMES: n_cfg.total_frames = i_cfg.data[TOTAL_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_position  <= '0;
            r_cfg.steps_per_frame <= '0;
            r_cfg.trigger_ms      <= 32'd100;
            r_cfg.shutter_ms      <= 32'd1000;
            r_cfg.interval_ms     <= 32'd3000;
            r_cfg.total_frames    <= TOTAL_BITS'(1);
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ===== sv/tls_step.sv =====
`timescale 1ns / 1ps

module tls_step
    import tls_pkg::*;
(
    input  t_state      i_state,
    input  t_cfg        i_cfg,
    input  logic [1:0]  i_cmd,
    input  logic [31:0] i_now_ms,
    input  logic        i_stepper_busy,
    output t_state      o_state,
    output t_result     o_result
);

    typedef struct packed {
        logic trig_old;
        logic trig_zero;
        logic shut_old;
        logic shut_zero;
        logic intv_old;
        logic intv_zero;
    } t_cmp;

    typedef struct packed {
        t_phase                phase;
        logic                  fresh;
        logic                  busy;
        logic                  shutter;
        logic [FRAME_BITS-1:0] count;
        t_move                 move;
        logic                  fin;
        logic                  go;
    } t_walk;

    // One phase transition; after a new frame starts the elapsed time is zero.
    function automatic t_walk walk_step(input t_walk w, input t_cmp c,
                                        input logic [TOTAL_BITS-1:0] total);
        t_walk s;
        logic  hit;
        s = w;
        s.go = 1'b0;
        if (w.go) begin
            case (w.phase)
                PH_POSITION: begin
                    if (!w.busy) begin
                        s.fresh = 1'b1;
                        s.shutter = 1'b1;
                        s.phase = PH_TRIGGER;
                        s.go = 1'b1;
                    end
                end
                PH_TRIGGER: begin
                    hit = w.fresh ? c.trig_zero : c.trig_old;
                    if (hit) begin
                        s.shutter = 1'b0;
                        s.phase = PH_EXPOSE;
                        s.go = 1'b1;
                    end
                end
                PH_EXPOSE: begin
                    hit = w.fresh ? c.shut_zero : c.shut_old;
                    if (hit) begin
                        s.move = MOVE_REL;
                        s.busy = 1'b1;
                        s.phase = PH_SHUTTLE;
                        s.go = 1'b1;
                    end
                end
                PH_SHUTTLE: begin
                    if (!w.busy) begin
                        s.phase = PH_WAIT;
                        s.go = 1'b1;
                    end
                end
                PH_WAIT: begin
                    hit = w.fresh ? c.intv_zero : c.intv_old;
                    if (hit) begin
                        if (w.count != {FRAME_BITS{1'b1}}) begin
                            s.count = w.count + FRAME_BITS'(1);
                        end
                        if (CMP_BITS'(s.count) >= CMP_BITS'(total)) begin
                            s.phase = PH_IDLE;
                            s.fin = 1'b1;
                        end else begin
                            s.fresh = 1'b1;
                            s.shutter = 1'b1;
                            s.phase = PH_TRIGGER;
                            s.go = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        return s;
    endfunction

    logic [31:0]         elapsed;
    t_cmp                cmp;
    t_walk               walk;
    logic [CMP_BITS-1:0] count_wide;

    assign elapsed = i_now_ms - i_state.frame_start;

    always_comb begin
        cmp.trig_old  = elapsed >= i_cfg.trigger_ms;
        cmp.trig_zero = i_cfg.trigger_ms == '0;
        cmp.shut_old  = elapsed >= i_cfg.shutter_ms;
        cmp.shut_zero = i_cfg.shutter_ms == '0;
        cmp.intv_old  = elapsed >= i_cfg.interval_ms;
        cmp.intv_zero = i_cfg.interval_ms == '0;
    end

    always_comb begin
        walk.phase   = i_state.phase;
        walk.fresh   = 1'b0;
        walk.busy    = i_stepper_busy;
        walk.shutter = i_state.shutter;
        walk.count   = i_state.count;
        walk.move    = MOVE_NONE;
        walk.fin     = 1'b0;
        walk.go      = 1'b0;
        case (t_cmd'(i_cmd))
            CMD_ABORT: begin
                walk.phase = PH_IDLE;
                walk.shutter = 1'b0;
            end
            CMD_BEGIN: begin
                if (i_state.phase == PH_IDLE) begin
                    walk.count = '0;
                    walk.move = MOVE_ABS;
                    walk.phase = PH_POSITION;
                end
            end
            CMD_TICK: begin
                walk.go = 1'b1;
                for (int i = 0; i < WALK_STEPS; i++) begin
                    walk = walk_step(walk, cmp, i_cfg.total_frames);
                end
            end
            default: begin
            end
        endcase
    end

    assign count_wide = CMP_BITS'(walk.count);

    always_comb begin
        o_state.phase       = walk.phase;
        o_state.frame_start = walk.fresh ? i_now_ms : i_state.frame_start;
        o_state.count       = walk.count;
        o_state.shutter     = walk.shutter;

        o_result.phase        = phase_code(walk.phase);
        o_result.shutter_line = walk.shutter;
        o_result.move_kind    = walk.move;
        case (walk.move)
            MOVE_ABS: o_result.move_amount = i_cfg.start_position;
            MOVE_REL: o_result.move_amount = i_cfg.steps_per_frame;
            default:  o_result.move_amount = '0;
        endcase
        o_result.frames_done = count_wide[TOTAL_BITS-1:0];
        o_result.finished    = walk.fin;
    end

endmodule

// ===== sv/timelapse_shot_sequencer.sv =====
`timescale 1ns / 1ps
// A request is held in the input register once accepted; its result enters the result register
// when the output is free. Throughput: one request per cycle while the output is not stalled,
// set by the single combinational pass from the input register through the sequencer state
// update into the result register.
// Reset is synchronous and active low: the sequencer returns to idle with the shutter low,
// the frame count and frame start cleared, and the configuration registers at their defaults.
module timelapse_shot_sequencer
    import tls_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    tls_in_if.sink    i_in,
    tls_out_if.source o_out,
    tls_cfg_if.sink   i_cfg
);

    t_cfg    cfg;
    t_state  r_state;
    t_state  n_state;
    t_result step_result;
    t_result r_result;

    logic        r_in_valid;
    logic [1:0]  r_in_cmd;
    logic [31:0] r_in_now_ms;
    logic        r_in_busy;
    logic        r_out_valid;
    logic        out_free;
    logic        fire;

    tls_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    tls_step u_step (
        .i_state        (r_state),
        .i_cfg          (cfg),
        .i_cmd          (r_in_cmd),
        .i_now_ms       (r_in_now_ms),
        .i_stepper_busy (r_in_busy),
        .o_state        (n_state),
        .o_result       (step_result)
    );

    assign out_free   = !r_out_valid || o_out.ready;
    assign fire       = r_in_valid && out_free;
    assign i_in.ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_cmd    <= i_in.cmd;
            r_in_now_ms <= i_in.now_ms;
            r_in_busy   <= i_in.stepper_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase       <= PH_IDLE;
            r_state.frame_start <= '0;
            r_state.count       <= '0;
            r_state.shutter     <= 1'b0;
        end else if (fire) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_result <= step_result;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.phase        = r_result.phase;
    assign o_out.shutter_line = r_result.shutter_line;
    assign o_out.move_kind    = r_result.move_kind;
    assign o_out.move_amount  = r_result.move_amount;
    assign o_out.frames_done  = r_result.frames_done;
    assign o_out.finished     = r_result.finished;

endmodule

// ===== sv/tls_checker.sv =====
`timescale 1ns / 1ps

module tls_checker
    import tls_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [2:0]         i_out_phase,
    input logic               i_out_shutter_line,
    input logic [1:0]         i_out_move_kind,
    input logic signed [31:0] i_out_move_amount,
    input logic               i_out_finished
);

    // A result that is not taken stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result request dropped while stalled");

    // The shutter line is only high while the trigger time runs.
    a_shutter_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_shutter_line |-> i_out_phase == CODE_TRIGGER)
        else $error("shutter line high outside the trigger phase");

    // The last frame returns the sequencer to idle.
    a_finish_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_finished |-> i_out_phase == CODE_IDLE
                                          && i_out_move_kind == MOVE_NONE)
        else $error("finished without returning to idle");

    // An absolute move is only commanded when positioning starts.
    a_abs_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_move_kind == MOVE_ABS |-> i_out_phase == CODE_POSITION)
        else $error("absolute move outside positioning");

    // No move means no move amount.
    a_no_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_move_kind == MOVE_NONE |-> i_out_move_amount == '0)
        else $error("move amount without a move");

endmodule

bind timelapse_shot_sequencer tls_checker u_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_out_valid        (o_out.valid),
    .i_out_ready        (o_out.ready),
    .i_out_phase        (o_out.phase),
    .i_out_shutter_line (o_out.shutter_line),
    .i_out_move_kind    (o_out.move_kind),
    .i_out_move_amount  (o_out.move_amount),
    .i_out_finished     (o_out.finished)
);
